>>> sv/epc_pkg.sv
`default_nettype none

package epc_pkg;

   // width of the shared compare-and-subtract unit
   localparam int unsigned UnitWidth   = 16;
   localparam int unsigned EpochWidth  = 32;
   localparam int unsigned RemWidth    = 6;
   localparam int unsigned DayWidth    = 16;
   localparam int unsigned YearWidth   = 8;
   localparam int unsigned MonthWidth  = 4;
   localparam int unsigned StepWidth   = 5;

   localparam logic [UnitWidth-1:0] SecsPerMin   = UnitWidth'(60);
   localparam logic [UnitWidth-1:0] MinsPerHour  = UnitWidth'(60);
   localparam logic [UnitWidth-1:0] HoursPerDay  = UnitWidth'(24);
   localparam logic [UnitWidth-1:0] DaysPerWeek  = UnitWidth'(7);
   localparam logic [UnitWidth-1:0] DaysLeapYear = UnitWidth'(366);
   localparam logic [UnitWidth-1:0] DaysYear     = UnitWidth'(365);

   // 1970-01-01 was a thursday
   localparam logic [DayWidth-1:0] WeekDayBias = DayWidth'(4);

   // year walk stops here whatever is left
   localparam logic [YearWidth-1:0] MaxYearSteps = YearWidth'(137);
   // 2100, the one century year in range that is not leap
   localparam logic [YearWidth-1:0] Year2100     = YearWidth'(130);
   localparam logic [MonthWidth-1:0] LastMonth   = MonthWidth'(11);

   typedef struct packed {
      logic                 ge;
      logic [UnitWidth-1:0] diff;
   } csub_result_type;

   // year offset from 1970: 1970 + off divisible by 4 when off mod 4 is 2
   function automatic logic is_leap(input logic [YearWidth-1:0] off);
      is_leap = (off[1:0] == 2'd2) && (off != Year2100);
   endfunction

   function automatic logic [4:0] month_len(input logic [MonthWidth-1:0] month,
                                            input logic leap);
      case (month)
         4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: month_len = 5'd31;
         4'd1:                                    month_len = leap ? 5'd29 : 5'd28;
         default:                                 month_len = 5'd30;
      endcase
   endfunction

endpackage

`default_nettype wire

>>> sv/epc_csub.sv
`default_nettype none

module epc_csub (
   input  wire logic [epc_pkg::UnitWidth-1:0] a,
   input  wire logic [epc_pkg::UnitWidth-1:0] b,
   output epc_pkg::csub_result_type           result
);
   import epc_pkg::*;

   logic [UnitWidth:0] wide_diff;

   assign wide_diff   = {1'b0, a} - {1'b0, b};
   assign result.ge   = ~wide_diff[UnitWidth];
   assign result.diff = wide_diff[UnitWidth-1:0];

endmodule

`default_nettype wire

>>> sv/epoch_to_calendar_core.sv
`default_nettype none

// epoch_to_calendar_core: unix seconds to broken-down gregorian time
//
// input channel req_*: one word holds a 32-bit count of seconds since
// 1970-01-01 00:00:00. the core takes a word only when idle; req_stall is
// high for the whole conversion.
// result channel rsp_*: one word per input word with second, minute, hour,
// weekday (1 is sunday), year minus 1970, month (1..12) and day (1..31).
//
// the three divisions by 60, 60 and 24 and the mod 7 for the weekday run
// one quotient bit per cycle, then the year walk takes one year per cycle
// and the month walk one month per cycle, all through a single shared
// compare-and-subtract unit. one word is in work at a time.
//
// the finished word sits in an output register, so a new word is accepted
// while rsp_stall holds the previous result; if the next result finishes
// before that one is taken, the core waits. reset clears the sequencer and
// rsp_valid.

module epoch_to_calendar_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_epoch_seconds,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [5:0]       rsp_second_of_minute,
   output logic [5:0]       rsp_minute_of_hour,
   output logic [4:0]       rsp_hour_of_day,
   output logic [2:0]       rsp_week_day,
   output logic [7:0]       rsp_year_offset,
   output logic [3:0]       rsp_month_number,
   output logic [4:0]       rsp_month_day
);
   import epc_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      DIV_SEC,
      DIV_MIN,
      DIV_HOUR,
      WDAY,
      YEAR_WALK,
      MONTH_WALK,
      FINISH
   } state_type;

   state_type               state_ff, state_in;
   logic [StepWidth-1:0]    step_ff, step_in;     // division bits left, minus one
   logic [EpochWidth-1:0]   q_ff, q_in;           // dividend in, quotient out
   logic [RemWidth-1:0]     rem_ff, rem_in;
   logic [RemWidth-1:0]     sec_ff, sec_in;
   logic [RemWidth-1:0]     min_ff, min_in;
   logic [4:0]              hour_ff, hour_in;
   logic [2:0]              wday_ff, wday_in;
   logic [DayWidth-1:0]     day_ff, day_in;       // days left to walk
   logic [YearWidth-1:0]    year_ff, year_in;
   logic [MonthWidth-1:0]   month_ff, month_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [5:0]              rsp_sec_ff, rsp_sec_in;
   logic [5:0]              rsp_min_ff, rsp_min_in;
   logic [4:0]              rsp_hour_ff, rsp_hour_in;
   logic [2:0]              rsp_wday_ff, rsp_wday_in;
   logic [7:0]              rsp_year_ff, rsp_year_in;
   logic [3:0]              rsp_month_ff, rsp_month_in;
   logic [4:0]              rsp_mday_ff, rsp_mday_in;

   // shared unit operands
   logic [UnitWidth-1:0]    unit_a;
   logic [UnitWidth-1:0]    unit_b;
   csub_result_type         unit_res;
   logic                    leap;
   logic                    div_state;
   logic [RemWidth-1:0]     div_rem;

   epc_csub u_csub (
      .a      (unit_a),
      .b      (unit_b),
      .result (unit_res)
   );

   assign leap      = is_leap(year_ff);
   assign div_state = (state_ff == DIV_SEC) || (state_ff == DIV_MIN) ||
                      (state_ff == DIV_HOUR) || (state_ff == WDAY);
   // remainder after this restoring step
   assign div_rem   = unit_res.ge ? unit_res.diff[RemWidth-1:0] : unit_a[RemWidth-1:0];

   // operand select for the shared unit
   always_comb begin
      unit_a = '0;
      unit_b = '0;
      unique case (state_ff)
         DIV_SEC: begin
            unit_a = {{(UnitWidth-RemWidth-1){1'b0}}, rem_ff, q_ff[EpochWidth-1]};
            unit_b = SecsPerMin;
         end
         DIV_MIN: begin
            unit_a = {{(UnitWidth-RemWidth-1){1'b0}}, rem_ff, q_ff[EpochWidth-1]};
            unit_b = MinsPerHour;
         end
         DIV_HOUR: begin
            unit_a = {{(UnitWidth-RemWidth-1){1'b0}}, rem_ff, q_ff[EpochWidth-1]};
            unit_b = HoursPerDay;
         end
         WDAY: begin
            unit_a = {{(UnitWidth-RemWidth-1){1'b0}}, rem_ff, q_ff[EpochWidth-1]};
            unit_b = DaysPerWeek;
         end
         YEAR_WALK: begin
            unit_a = day_ff;
            unit_b = leap ? DaysLeapYear : DaysYear;
         end
         MONTH_WALK: begin
            unit_a = day_ff;
            unit_b = {{(UnitWidth-5){1'b0}}, month_len(month_ff, leap)};
         end
         default: begin
            unit_a = '0;
            unit_b = '0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      q_in         = q_ff;
      rem_in       = rem_ff;
      sec_in       = sec_ff;
      min_in       = min_ff;
      hour_in      = hour_ff;
      wday_in      = wday_ff;
      day_in       = day_ff;
      year_in      = year_ff;
      month_in     = month_ff;

      // result register empties when taken
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_sec_in   = rsp_sec_ff;
      rsp_min_in   = rsp_min_ff;
      rsp_hour_in  = rsp_hour_ff;
      rsp_wday_in  = rsp_wday_ff;
      rsp_year_in  = rsp_year_ff;
      rsp_month_in = rsp_month_ff;
      rsp_mday_in  = rsp_mday_ff;

      // one restoring division step, shared by all division states
      if (div_state) begin
         q_in   = {q_ff[EpochWidth-2:0], unit_res.ge};
         rem_in = div_rem;
         step_in = step_ff - StepWidth'(1);
      end

      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               q_in     = req_epoch_seconds;
               rem_in   = '0;
               step_in  = StepWidth'(31);
               state_in = DIV_SEC;
            end
         end
         DIV_SEC: begin
            if (step_ff == '0) begin
               // quotient below 2^27, align it to the top
               sec_in   = div_rem;
               q_in     = {q_ff[25:0], unit_res.ge, 5'b0};
               rem_in   = '0;
               step_in  = StepWidth'(26);
               state_in = DIV_MIN;
            end
         end
         DIV_MIN: begin
            if (step_ff == '0) begin
               // quotient below 2^21
               min_in   = div_rem;
               q_in     = {q_ff[19:0], unit_res.ge, 11'b0};
               rem_in   = '0;
               step_in  = StepWidth'(20);
               state_in = DIV_HOUR;
            end
         end
         DIV_HOUR: begin
            if (step_ff == '0) begin
               // day count fits 16 bits; bias it for the weekday
               hour_in  = div_rem[4:0];
               day_in   = {q_ff[14:0], unit_res.ge};
               q_in     = {{q_ff[14:0], unit_res.ge} + WeekDayBias, 16'b0};
               rem_in   = '0;
               step_in  = StepWidth'(15);
               state_in = WDAY;
            end
         end
         WDAY: begin
            if (step_ff == '0) begin
               wday_in  = div_rem[2:0] + 3'd1;
               year_in  = '0;
               state_in = YEAR_WALK;
            end
         end
         YEAR_WALK: begin
            if ((year_ff == MaxYearSteps) || !unit_res.ge) begin
               month_in = '0;
               state_in = MONTH_WALK;
            end else begin
               day_in  = unit_res.diff;
               year_in = year_ff + YearWidth'(1);
            end
         end
         MONTH_WALK: begin
            if ((month_ff == LastMonth) || !unit_res.ge) begin
               state_in = FINISH;
            end else begin
               day_in   = unit_res.diff;
               month_in = month_ff + MonthWidth'(1);
            end
         end
         FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_sec_in   = sec_ff;
               rsp_min_in   = min_ff;
               rsp_hour_in  = hour_ff;
               rsp_wday_in  = wday_ff;
               rsp_year_in  = year_ff;
               rsp_month_in = month_ff + MonthWidth'(1);
               rsp_mday_in  = day_ff[4:0] + 5'd1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff      <= step_in;
      q_ff         <= q_in;
      rem_ff       <= rem_in;
      sec_ff       <= sec_in;
      min_ff       <= min_in;
      hour_ff      <= hour_in;
      wday_ff      <= wday_in;
      day_ff       <= day_in;
      year_ff      <= year_in;
      month_ff     <= month_in;
      rsp_sec_ff   <= rsp_sec_in;
      rsp_min_ff   <= rsp_min_in;
      rsp_hour_ff  <= rsp_hour_in;
      rsp_wday_ff  <= rsp_wday_in;
      rsp_year_ff  <= rsp_year_in;
      rsp_month_ff <= rsp_month_in;
      rsp_mday_ff  <= rsp_mday_in;
   end

   // ports
   assign req_stall            = (state_ff != IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_second_of_minute = rsp_sec_ff;
   assign rsp_minute_of_hour   = rsp_min_ff;
   assign rsp_hour_of_day      = rsp_hour_ff;
   assign rsp_week_day         = rsp_wday_ff;
   assign rsp_year_offset      = rsp_year_ff;
   assign rsp_month_number     = rsp_month_ff;
   assign rsp_month_day        = rsp_mday_ff;

endmodule

`default_nettype wire

>>> tb/tb_epoch_to_calendar_core.sv
`timescale 1ns / 1ps

module tb_epoch_to_calendar_core;

   localparam int unsigned CycleLimit = 1_500_000;
   localparam int unsigned SecsPerDay = 86400;
   localparam int unsigned DrainCycles = 300;
   localparam int unsigned RandomWords = 1100;
   localparam int unsigned QuietWords = 100;
   localparam int unsigned LongHoldCycles = 800;

   typedef struct packed {
      logic [5:0] second_of_minute;
      logic [5:0] minute_of_hour;
      logic [4:0] hour_of_day;
      logic [2:0] week_day;
      logic [7:0] year_offset;
      logic [3:0] month_number;
      logic [4:0] month_day;
   } calendar_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_epoch_seconds = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [5:0]  rsp_second_of_minute;
   logic [5:0]  rsp_minute_of_hour;
   logic [4:0]  rsp_hour_of_day;
   logic [2:0]  rsp_week_day;
   logic [7:0]  rsp_year_offset;
   logic [3:0]  rsp_month_number;
   logic [4:0]  rsp_month_day;

   logic [31:0]  pending_epochs[$];
   calendar_type calendar_due[$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned send_gap = 0;
   int unsigned stall_left = 0;
   int unsigned hold_left = 0;
   int unsigned words_taken = 0;
   bit          hold_done = 1'b0;
   logic        quiet_tail = 1'b0;

   epoch_to_calendar_core u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_epoch_seconds    (req_epoch_seconds),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_second_of_minute (rsp_second_of_minute),
      .rsp_minute_of_hour   (rsp_minute_of_hour),
      .rsp_hour_of_day      (rsp_hour_of_day),
      .rsp_week_day         (rsp_week_day),
      .rsp_year_offset      (rsp_year_offset),
      .rsp_month_number     (rsp_month_number),
      .rsp_month_day        (rsp_month_day)
   );

   // gregorian rule on the calendar year 1970 + off
   function automatic bit gregorian_leap(input int unsigned off);
      int unsigned yr;
      yr = 1970 + off;
      gregorian_leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
   endfunction

   function automatic int unsigned month_length(input int unsigned mo, input bit leap);
      case (mo)
         0, 2, 4, 6, 7, 9, 11: month_length = 31;
         1:                    month_length = leap ? 29 : 28;
         default:              month_length = 30;
      endcase
   endfunction

   // broken-down time for one count of seconds
   function automatic calendar_type to_calendar(input logic [31:0] secs);
      calendar_type c;
      int unsigned  t;
      int unsigned  yr;
      int unsigned  mo;
      t = secs;
      c.second_of_minute = 6'(t % 60);
      t = t / 60;
      c.minute_of_hour = 6'(t % 60);
      t = t / 60;
      c.hour_of_day = 5'(t % 24);
      t = t / 24;
      // day zero was a thursday, sunday is 1
      c.week_day = 3'((t + 4) % 7 + 1);
      yr = 0;
      while (yr < 137 && t >= (gregorian_leap(yr) ? 366 : 365)) begin
         t = t - (gregorian_leap(yr) ? 366 : 365);
         yr++;
      end
      mo = 0;
      while (mo < 11 && t >= month_length(mo, gregorian_leap(yr))) begin
         t = t - month_length(mo, gregorian_leap(yr));
         mo++;
      end
      c.year_offset = 8'(yr);
      c.month_number = 4'(mo + 1);
      c.month_day = 5'(t + 1);
      return c;
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // sender: offers the next pending word once the current one is taken, with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         quiet_tail <= 1'b0;
      end else begin
         quiet_tail <= (pending_epochs.size() < QuietWords);
         if (req_valid && !req_stall)
            calendar_due.push_back(to_calendar(req_epoch_seconds));
         if (!req_valid || !req_stall) begin
            if (send_gap == 0 && !quiet_tail && $urandom_range(0, 7) == 0)
               send_gap = $urandom_range(1, 13);
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_epochs.size() > 0) begin
               req_valid <= 1'b1;
               req_epoch_seconds <= pending_epochs.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each taken word, stalls in bursts, one long hold early on
   always @(posedge clock) begin
      calendar_type got;
      calendar_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            words_taken++;
            got.second_of_minute = rsp_second_of_minute;
            got.minute_of_hour = rsp_minute_of_hour;
            got.hour_of_day = rsp_hour_of_day;
            got.week_day = rsp_week_day;
            got.year_offset = rsp_year_offset;
            got.month_number = rsp_month_number;
            got.month_day = rsp_month_day;
            if (calendar_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result word with no input outstanding: %p", got);
            end else begin
               want = calendar_due.pop_front();
               if (got.second_of_minute !== want.second_of_minute ||
                   got.minute_of_hour !== want.minute_of_hour ||
                   got.hour_of_day !== want.hour_of_day ||
                   got.week_day !== want.week_day ||
                   got.year_offset !== want.year_offset ||
                   got.month_number !== want.month_number ||
                   got.month_day !== want.month_day) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch at word %0d: expected %p, got %p",
                              words_taken, want, got);
               end
            end
         end
         if (!hold_done && words_taken >= 60) begin
            hold_done = 1'b1;
            hold_left = LongHoldCycles;
         end
         if (hold_left == 0 && stall_left == 0 && !quiet_tail &&
             $urandom_range(0, 19) == 0)
            stall_left = $urandom_range(1, 13);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      wait (cycle_count >= CycleLimit);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int unsigned     pick;
      int unsigned     days;
      longint unsigned secs;

      // field edges, day and month rollovers, leap and century cases, top of range
      pending_epochs.push_back(32'd0);
      pending_epochs.push_back(32'd1);
      pending_epochs.push_back(32'd59);
      pending_epochs.push_back(32'd60);
      pending_epochs.push_back(32'd3599);
      pending_epochs.push_back(32'd3600);
      pending_epochs.push_back(32'd86399);
      pending_epochs.push_back(32'd86400);
      pending_epochs.push_back(32'd2678400);      // first of february 1970
      pending_epochs.push_back(32'd68169600);     // feb 29 1972
      pending_epochs.push_back(32'd94608000);     // day 366 of a leap year
      pending_epochs.push_back(32'd94694400);
      pending_epochs.push_back(32'd946684799);    // last second of 1999
      pending_epochs.push_back(32'd951782400);    // feb 29 2000, divisible by 400
      pending_epochs.push_back(32'd951868800);
      pending_epochs.push_back(32'd978220800);    // dec 31 2000
      pending_epochs.push_back(32'h7FFF_FFFF);
      pending_epochs.push_back(32'h8000_0000);
      pending_epochs.push_back(32'd4102444799);   // last second of 2099
      pending_epochs.push_back(32'd4102444800);
      pending_epochs.push_back(32'd4107542399);   // feb 28 2100, century not leap
      pending_epochs.push_back(32'd4107542400);   // straight to march 1
      pending_epochs.push_back(32'd4291747199);   // end of 2105
      pending_epochs.push_back(32'hFFFF_FFFE);
      pending_epochs.push_back(32'hFFFF_FFFF);

      for (int n = 0; n < RandomWords; n++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: secs = 64'($urandom);
            4, 5: begin
               // around midnight of some day
               secs = longint'($urandom_range(1, 49710)) * SecsPerDay;
               case ($urandom_range(0, 2))
                  0: secs = secs - 1;
                  1: ;
                  default: secs = secs + $urandom_range(0, SecsPerDay - 1);
               endcase
            end
            6: begin
               // new year, landing on either side
               pick = $urandom_range(1, 136);
               days = 0;
               for (int y = 0; y < pick; y++)
                  days += gregorian_leap(y) ? 366 : 365;
               secs = longint'(days) * SecsPerDay - $urandom_range(0, 1);
            end
            7: secs = (($urandom_range(0, 1) != 0) ? 64'd951696000 : 64'd4107456000)
                      + $urandom_range(0, 3 * SecsPerDay);
            8: secs = 64'hFFFF_FFFF - $urandom_range(0, 40_000_000);
            default: secs = $urandom_range(0, 100_000_000);
         endcase
         pending_epochs.push_back(secs[31:0]);
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_epochs.size() > 0 || req_valid) @(posedge clock);
      while (calendar_due.size() > 0) @(posedge clock);
      // room for a stray word to show up
      repeat (DrainCycles) @(posedge clock);

      if (mismatch_count == 0 && calendar_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
